// File: rtl/csic_pkg.sv
// shared types, codes and constants for the cpu subset instruction core
// used by the controller, the datapath, the top level and the checker
// depends on nothing
package csic_pkg;

  // default address width of the byte memory
  localparam int unsigned ADDR_BITS_DEF = 16;

  // command codes of an input word
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  // implemented opcodes
  localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
  localparam logic [7:0] OP_BEQ      = 8'hF0;
  localparam logic [7:0] OP_STA_ABS  = 8'h8D;
  localparam logic [7:0] OP_INX      = 8'hE8;
  localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
  localparam logic [7:0] OP_BRK      = 8'h00;

  // status flag masks
  localparam logic [7:0] FLAG_N = 8'h80;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_Z = 8'h02;

  // fixed addresses and reset values
  localparam logic [15:0] STACK_BASE = 16'h0100;
  localparam logic [15:0] VEC_RESET  = 16'hFFFC;
  localparam logic [15:0] VEC_IRQ    = 16'hFFFE;
  localparam logic [7:0]  SP_RESET   = 8'hFD;

  // memory address source
  typedef enum logic [3:0] {
    AS_CLR,
    AS_ITEM,
    AS_PC0,
    AS_PC1,
    AS_PC2,
    AS_ABS,
    AS_ABSX,
    AS_STACK,
    AS_VECLO,
    AS_VECHI
  } addr_sel_e;

  // memory write data source
  typedef enum logic [2:0] {
    WD_ZERO,
    WD_ITEM,
    WD_ACC,
    WD_PCH,
    WD_PCL,
    WD_PSTAT
  } wdat_sel_e;

  // register update selected by the controller
  typedef enum logic [3:0] {
    RO_NONE,
    RO_LDX,
    RO_BEQ,
    RO_INX,
    RO_HALT,
    RO_JMP,
    RO_LDA,
    RO_STA,
    RO_PUSH,
    RO_PUSHP,
    RO_CAP_RD
  } reg_op_e;

  // controller to datapath commands
  typedef struct packed {
    addr_sel_e addr_sel;
    logic      mem_we;
    wdat_sel_e wdat_sel;
    logic      take_item;
    logic      lat_op;
    logic      lat_lo;
    logic      lat_hi;
    reg_op_e   reg_op;
    logic      load_out;
    logic      clr_step;
  } csic_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       clr_last;
    logic       halted;
    logic [7:0] opcode;
    logic       out_busy;
  } csic_stat_t;

  // command with nothing to do
  localparam csic_cmd_t CMD_NOP = '{
    addr_sel:  AS_PC0,
    mem_we:    1'b0,
    wdat_sel:  WD_ZERO,
    take_item: 1'b0,
    lat_op:    1'b0,
    lat_lo:    1'b0,
    lat_hi:    1'b0,
    reg_op:    RO_NONE,
    load_out:  1'b0,
    clr_step:  1'b0
  };

endpackage

// File: rtl/csic_dp.sv
// datapath of the cpu subset core: byte memory, cpu registers, operand
// latches and the output word register
// depends on csic_pkg
module csic_dp #(
  parameter int unsigned ADDR_BITS = csic_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csic_pkg::csic_cmd_t   ctrl_i,
  output csic_pkg::csic_stat_t  stat_o,
  input  logic [ADDR_BITS-1:0]  mem_address_i,
  input  logic [7:0]            write_data_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            read_data_o,
  output logic [ADDR_BITS-1:0]  program_counter_o,
  output logic [7:0]            accumulator_o,
  output logic [7:0]            index_x_o,
  output logic [7:0]            stack_pointer_o,
  output logic [7:0]            status_flags_o,
  output logic                  halted_o,
  output logic [7:0]            fetched_opcode_o
);

  localparam int unsigned MemDepth = 2 ** ADDR_BITS;

  // update z and n from a loaded value
  function automatic logic [7:0] set_zn(input logic [7:0] flags, input logic [7:0] val);
    logic [7:0] res;
    res = flags & ~(csic_pkg::FLAG_Z | csic_pkg::FLAG_N);
    if (val == 8'h00) res = res | csic_pkg::FLAG_Z;
    if (val[7]) res = res | csic_pkg::FLAG_N;
    return res;
  endfunction

  logic [7:0]           mem_q [MemDepth];
  logic [7:0]           mem_rdata_q;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata;

  logic [ADDR_BITS-1:0] clr_cnt_q;
  logic [ADDR_BITS-1:0] pc_q;
  logic [7:0]           acc_q;
  logic [7:0]           x_q;
  logic [7:0]           sp_q;
  logic [7:0]           flags_q;
  logic                 halt_q;

  logic [ADDR_BITS-1:0] item_addr_q;
  logic [7:0]           item_data_q;
  logic [7:0]           op_q;
  logic [7:0]           rdat_q;
  logic [7:0]           lo_q;
  logic [7:0]           hi_q;
  logic                 out_valid_q;

  logic [ADDR_BITS-1:0] pc_inc1;
  logic [ADDR_BITS-1:0] pc_inc2;
  logic [ADDR_BITS-1:0] pc_inc3;
  logic [ADDR_BITS-1:0] abs_addr;
  logic [ADDR_BITS-1:0] branch_tgt;
  logic [7:0]           x_inc;

  // address arithmetic, all modulo the memory size
  assign pc_inc1    = pc_q + ADDR_BITS'(1);
  assign pc_inc2    = pc_q + ADDR_BITS'(2);
  assign pc_inc3    = pc_q + ADDR_BITS'(3);
  assign abs_addr   = ADDR_BITS'({hi_q, lo_q});
  assign branch_tgt = pc_inc2 + ADDR_BITS'({{(ADDR_BITS - 8){mem_rdata_q[7]}}, mem_rdata_q});
  assign x_inc      = x_q + 8'd1;

  // memory address select
  always_comb begin
    case (ctrl_i.addr_sel)
      csic_pkg::AS_CLR:   mem_addr = clr_cnt_q;
      csic_pkg::AS_ITEM:  mem_addr = item_addr_q;
      csic_pkg::AS_PC0:   mem_addr = pc_q;
      csic_pkg::AS_PC1:   mem_addr = pc_inc1;
      csic_pkg::AS_PC2:   mem_addr = pc_inc2;
      csic_pkg::AS_ABS:   mem_addr = abs_addr;
      csic_pkg::AS_ABSX:  mem_addr = abs_addr + ADDR_BITS'(x_q);
      csic_pkg::AS_STACK: mem_addr = ADDR_BITS'(csic_pkg::STACK_BASE) + ADDR_BITS'(sp_q);
      csic_pkg::AS_VECLO: mem_addr = ADDR_BITS'(csic_pkg::VEC_IRQ);
      csic_pkg::AS_VECHI: mem_addr = ADDR_BITS'(csic_pkg::VEC_IRQ) + ADDR_BITS'(1);
      default:            mem_addr = pc_q;
    endcase
  end

  // memory write data select
  always_comb begin
    case (ctrl_i.wdat_sel)
      csic_pkg::WD_ZERO:  mem_wdata = 8'h00;
      csic_pkg::WD_ITEM:  mem_wdata = item_data_q;
      csic_pkg::WD_ACC:   mem_wdata = acc_q;
      csic_pkg::WD_PCH:   mem_wdata = 8'(pc_inc2 >> 8);
      csic_pkg::WD_PCL:   mem_wdata = 8'(pc_inc2);
      csic_pkg::WD_PSTAT: mem_wdata = flags_q | csic_pkg::FLAG_B;
      default:            mem_wdata = 8'h00;
    endcase
  end

  // single port byte memory with registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_addr];
  end

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
    end
  end

  // cpu registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= ADDR_BITS'(csic_pkg::VEC_RESET);
      acc_q   <= 8'h00;
      x_q     <= 8'h00;
      sp_q    <= csic_pkg::SP_RESET;
      flags_q <= 8'h00;
      halt_q  <= 1'b0;
    end else begin
      case (ctrl_i.reg_op)
        csic_pkg::RO_LDX: begin
          x_q     <= mem_rdata_q;
          flags_q <= set_zn(flags_q, mem_rdata_q);
          pc_q    <= pc_inc2;
        end
        csic_pkg::RO_BEQ: begin
          pc_q <= ((flags_q & csic_pkg::FLAG_Z) != 8'h00) ? branch_tgt : pc_inc2;
        end
        csic_pkg::RO_INX: begin
          x_q     <= x_inc;
          flags_q <= set_zn(flags_q, x_inc);
          pc_q    <= pc_inc1;
        end
        csic_pkg::RO_HALT: begin
          halt_q <= 1'b1;
        end
        csic_pkg::RO_JMP: begin
          pc_q <= ADDR_BITS'({mem_rdata_q, lo_q});
        end
        csic_pkg::RO_LDA: begin
          acc_q   <= mem_rdata_q;
          flags_q <= set_zn(flags_q, mem_rdata_q);
          pc_q    <= pc_inc3;
        end
        csic_pkg::RO_STA: begin
          pc_q <= pc_inc3;
        end
        csic_pkg::RO_PUSH: begin
          sp_q <= sp_q - 8'd1;
        end
        csic_pkg::RO_PUSHP: begin
          sp_q    <= sp_q - 8'd1;
          flags_q <= (flags_q | csic_pkg::FLAG_I) & ~csic_pkg::FLAG_B;
        end
        default: begin
        end
      endcase
    end
  end

  // input word and operand latches
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_item) begin
      item_addr_q <= mem_address_i;
      item_data_q <= write_data_i;
      op_q        <= 8'h00;
      rdat_q      <= 8'h00;
    end else begin
      if (ctrl_i.lat_op) op_q <= mem_rdata_q;
      if (ctrl_i.reg_op == csic_pkg::RO_CAP_RD) rdat_q <= mem_rdata_q;
    end
    if (ctrl_i.lat_lo) lo_q <= mem_rdata_q;
    if (ctrl_i.lat_hi) hi_q <= mem_rdata_q;
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      read_data_o       <= rdat_q;
      program_counter_o <= pc_q;
      accumulator_o     <= acc_q;
      index_x_o         <= x_q;
      stack_pointer_o   <= sp_q;
      status_flags_o    <= flags_q;
      halted_o          <= halt_q;
      fetched_opcode_o  <= op_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.clr_last = &clr_cnt_q;
  assign stat_o.halted   = halt_q;
  assign stat_o.opcode   = op_q;
  assign stat_o.out_busy = out_valid_q & out_stall_i;

endmodule

// File: rtl/csic_ctrl.sv
// controller of the cpu subset core: sequences the clearing pass, the
// memory commands and the instruction steps over the shared memory port
// depends on csic_pkg
module csic_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            cmd_i,
  input  csic_pkg::csic_stat_t  stat_i,
  output logic                  in_stall_o,
  output csic_pkg::csic_cmd_t   ctrl_o
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_RDCAP,
    S_FETCH,
    S_OPC,
    S_DEC,
    S_HI,
    S_ABSX,
    S_LDA,
    S_STA,
    S_PUSH2,
    S_PUSH3,
    S_VECLO,
    S_VECHI,
    S_VECLD,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = csic_pkg::CMD_NOP;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.addr_sel = csic_pkg::AS_CLR;
        ctrl_o.mem_we   = 1'b1;
        ctrl_o.wdat_sel = csic_pkg::WD_ZERO;
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.take_item = 1'b1;
          case (cmd_i)
            csic_pkg::CMD_WRITE: state_d = S_WRITE;
            csic_pkg::CMD_READ:  state_d = S_READ;
            csic_pkg::CMD_EXEC:  state_d = stat_i.halted ? S_DONE : S_FETCH;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        ctrl_o.addr_sel = csic_pkg::AS_ITEM;
        ctrl_o.mem_we   = 1'b1;
        ctrl_o.wdat_sel = csic_pkg::WD_ITEM;
        state_d         = S_DONE;
      end
      S_READ: begin
        ctrl_o.addr_sel = csic_pkg::AS_ITEM;
        state_d         = S_RDCAP;
      end
      S_RDCAP: begin
        ctrl_o.reg_op = csic_pkg::RO_CAP_RD;
        state_d       = S_DONE;
      end
      S_FETCH: begin
        ctrl_o.addr_sel = csic_pkg::AS_PC0;
        state_d         = S_OPC;
      end
      // opcode arrives, first operand byte requested
      S_OPC: begin
        ctrl_o.lat_op   = 1'b1;
        ctrl_o.addr_sel = csic_pkg::AS_PC1;
        state_d         = S_DEC;
      end
      // decode with the first operand byte on the read port
      S_DEC: begin
        case (stat_i.opcode)
          csic_pkg::OP_LDX_IMM: begin
            ctrl_o.reg_op = csic_pkg::RO_LDX;
            state_d       = S_DONE;
          end
          csic_pkg::OP_BEQ: begin
            ctrl_o.reg_op = csic_pkg::RO_BEQ;
            state_d       = S_DONE;
          end
          csic_pkg::OP_INX: begin
            ctrl_o.reg_op = csic_pkg::RO_INX;
            state_d       = S_DONE;
          end
          csic_pkg::OP_LDA_ABSX, csic_pkg::OP_STA_ABS, csic_pkg::OP_JMP_ABS: begin
            ctrl_o.lat_lo   = 1'b1;
            ctrl_o.addr_sel = csic_pkg::AS_PC2;
            state_d         = S_HI;
          end
          csic_pkg::OP_BRK: begin
            ctrl_o.addr_sel = csic_pkg::AS_STACK;
            ctrl_o.mem_we   = 1'b1;
            ctrl_o.wdat_sel = csic_pkg::WD_PCH;
            ctrl_o.reg_op   = csic_pkg::RO_PUSH;
            state_d         = S_PUSH2;
          end
          default: begin
            ctrl_o.reg_op = csic_pkg::RO_HALT;
            state_d       = S_DONE;
          end
        endcase
      end
      // high operand byte on the read port
      S_HI: begin
        if (stat_i.opcode == csic_pkg::OP_JMP_ABS) begin
          ctrl_o.reg_op = csic_pkg::RO_JMP;
          state_d       = S_DONE;
        end else begin
          ctrl_o.lat_hi = 1'b1;
          state_d       = (stat_i.opcode == csic_pkg::OP_LDA_ABSX) ? S_ABSX : S_STA;
        end
      end
      S_ABSX: begin
        ctrl_o.addr_sel = csic_pkg::AS_ABSX;
        state_d         = S_LDA;
      end
      S_LDA: begin
        ctrl_o.reg_op = csic_pkg::RO_LDA;
        state_d       = S_DONE;
      end
      S_STA: begin
        ctrl_o.addr_sel = csic_pkg::AS_ABS;
        ctrl_o.mem_we   = 1'b1;
        ctrl_o.wdat_sel = csic_pkg::WD_ACC;
        ctrl_o.reg_op   = csic_pkg::RO_STA;
        state_d         = S_DONE;
      end
      // break: remaining pushes then the irq vector
      S_PUSH2: begin
        ctrl_o.addr_sel = csic_pkg::AS_STACK;
        ctrl_o.mem_we   = 1'b1;
        ctrl_o.wdat_sel = csic_pkg::WD_PCL;
        ctrl_o.reg_op   = csic_pkg::RO_PUSH;
        state_d         = S_PUSH3;
      end
      S_PUSH3: begin
        ctrl_o.addr_sel = csic_pkg::AS_STACK;
        ctrl_o.mem_we   = 1'b1;
        ctrl_o.wdat_sel = csic_pkg::WD_PSTAT;
        ctrl_o.reg_op   = csic_pkg::RO_PUSHP;
        state_d         = S_VECLO;
      end
      S_VECLO: begin
        ctrl_o.addr_sel = csic_pkg::AS_VECLO;
        state_d         = S_VECHI;
      end
      S_VECHI: begin
        ctrl_o.lat_lo   = 1'b1;
        ctrl_o.addr_sel = csic_pkg::AS_VECHI;
        state_d         = S_VECLD;
      end
      S_VECLD: begin
        ctrl_o.reg_op = csic_pkg::RO_JMP;
        state_d       = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/cpu_subset_instruction_core_unit.sv
// Top level of the cpu subset instruction core: controller plus datapath.
// Depends on csic_pkg, csic_ctrl and csic_dp.
//
// Usage: each input word carries a command (write a memory byte, read a
// memory byte, or run the instruction at the program counter), an address
// and write data. Each accepted word yields exactly one output word with the
// read byte, the cpu registers after the command, the halted flag and the
// opcode that was fetched. Both channels use valid and stall.
// An execute while halted or an unused command makes no memory access and
// goes straight to the output stage. All accesses go through one
// single-port memory, so the memory accesses of an instruction are made one
// after another; one word is in flight at a time and the next word is
// accepted in the cycle after the result enters the output register.
// After reset the memory is cleared one byte per cycle, all 65536 bytes for
// the default 16-bit address, with in_stall_o high throughout. A stalled
// output word holds; a finished result then waits in the controller until
// the output register frees, while the input stays stalled.
module cpu_subset_instruction_core_unit #(
  parameter int unsigned ADDR_BITS = csic_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [ADDR_BITS-1:0] mem_address_i,
  input  logic [7:0]           write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_data_o,
  output logic [ADDR_BITS-1:0] program_counter_o,
  output logic [7:0]           accumulator_o,
  output logic [7:0]           index_x_o,
  output logic [7:0]           stack_pointer_o,
  output logic [7:0]           status_flags_o,
  output logic                 halted_o,
  output logic [7:0]           fetched_opcode_o
);

  csic_pkg::csic_cmd_t  ctrl;
  csic_pkg::csic_stat_t stat;

  // sequencer
  csic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  // memory, registers and output word
  csic_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .mem_address_i     (mem_address_i),
    .write_data_i      (write_data_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .read_data_o       (read_data_o),
    .program_counter_o (program_counter_o),
    .accumulator_o     (accumulator_o),
    .index_x_o         (index_x_o),
    .stack_pointer_o   (stack_pointer_o),
    .status_flags_o    (status_flags_o),
    .halted_o          (halted_o),
    .fetched_opcode_o  (fetched_opcode_o)
  );

endmodule

// File: rtl/csic_chk.sv
// port checker for the cpu subset instruction core, bound to the top level
// depends on csic_pkg for the default address width
module csic_chk #(
  parameter int unsigned ADDR_BITS = csic_pkg::ADDR_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [7:0]           read_data_o,
  input logic [ADDR_BITS-1:0] program_counter_o,
  input logic                 halted_o,
  input logic [7:0]           fetched_opcode_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(program_counter_o)
      && $stable(fetched_opcode_o))
    else $error("stalled output word changed");

  // one word in flight: input stalls right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // a new output word only comes from a word in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a word in flight");

  // halted is sticky across output words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o && halted_o) |-> halted_o)
    else $error("halted flag cleared");

  // a word is never both a read and an executed fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_data_o == 8'h00) || (fetched_opcode_o == 8'h00))
    else $error("read data and fetched opcode both set");

endmodule

bind cpu_subset_instruction_core_unit csic_chk #(
  .ADDR_BITS (ADDR_BITS)
) u_csic_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .read_data_o       (read_data_o),
  .program_counter_o (program_counter_o),
  .halted_o          (halted_o),
  .fetched_opcode_o  (fetched_opcode_o)
);

// File: verif/tb_cpu_subset_instruction_core_unit.sv
// self-checking testbench for cpu_subset_instruction_core_unit: directed words, then random
// programs written into memory and executed, checked against an in-bench model of the core
// depends on csic_pkg and the rtl of the core unit
module tb_cpu_subset_instruction_core_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // the command value that the core leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic        halt;
    logic [7:0]  op;
  } core_snapshot_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = csic_pkg::CMD_WRITE;
  logic [15:0] mem_address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_data_o;
  logic [15:0] program_counter_o;
  logic [7:0]  accumulator_o;
  logic [7:0]  index_x_o;
  logic [7:0]  stack_pointer_o;
  logic [7:0]  status_flags_o;
  logic        halted_o;
  logic [7:0]  fetched_opcode_o;

  // words waiting to be sent and core snapshots waiting to come out
  cmd_word_t      cmd_words_q [$];
  core_snapshot_t snapshot_q [$];
  int             words_queued = 0;
  int             errors = 0;

  // model of the core: memory and registers
  logic [7:0]  core_mem [65536];
  logic [15:0] m_pc;
  logic [7:0]  m_acc;
  logic [7:0]  m_x;
  logic [7:0]  m_sp;
  logic [7:0]  m_flags;
  logic        m_halt;

  // sender and receiver idling state
  cmd_word_t next_word;
  int        burst_left = 0;
  int        send_gap = 0;
  int        stall_mode = 0;
  int        stall_len = 0;
  core_snapshot_t exp_snap;

  cpu_subset_instruction_core_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .mem_address_i     (mem_address_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .program_counter_o (program_counter_o),
    .accumulator_o     (accumulator_o),
    .index_x_o         (index_x_o),
    .stack_pointer_o   (stack_pointer_o),
    .status_flags_o    (status_flags_o),
    .halted_o          (halted_o),
    .fetched_opcode_o  (fetched_opcode_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [15:0] fetch_word(logic [15:0] a);
    logic [15:0] a_hi;
    a_hi = a + 16'd1;
    return {core_mem[a_hi], core_mem[a]};
  endfunction

  function automatic void update_zn(logic [7:0] v);
    m_flags = m_flags & ~(csic_pkg::FLAG_Z | csic_pkg::FLAG_N);
    if (v == 8'h00) m_flags = m_flags | csic_pkg::FLAG_Z;
    if (v[7]) m_flags = m_flags | csic_pkg::FLAG_N;
  endfunction

  function automatic void push_stack(logic [7:0] v);
    core_mem[csic_pkg::STACK_BASE + {8'h00, m_sp}] = v;
    m_sp = m_sp - 8'd1;
  endfunction

  // run the instruction at the program counter, return its opcode
  function automatic logic [7:0] exec_instr();
    logic [7:0]  op;
    logic [7:0]  off;
    logic [15:0] tgt;
    logic [15:0] ret;
    op = core_mem[m_pc];
    case (op)
      csic_pkg::OP_LDX_IMM: begin
        m_x = core_mem[m_pc + 16'd1];
        m_pc = m_pc + 16'd2;
        update_zn(m_x);
      end
      csic_pkg::OP_LDA_ABSX: begin
        tgt = fetch_word(m_pc + 16'd1) + {8'h00, m_x};
        m_acc = core_mem[tgt];
        m_pc = m_pc + 16'd3;
        update_zn(m_acc);
      end
      csic_pkg::OP_BEQ: begin
        off = core_mem[m_pc + 16'd1];
        tgt = m_pc + 16'd2;
        if ((m_flags & csic_pkg::FLAG_Z) != 8'h00) tgt = tgt + {{8{off[7]}}, off};
        m_pc = tgt;
      end
      csic_pkg::OP_STA_ABS: begin
        core_mem[fetch_word(m_pc + 16'd1)] = m_acc;
        m_pc = m_pc + 16'd3;
      end
      csic_pkg::OP_INX: begin
        m_x = m_x + 8'd1;
        m_pc = m_pc + 16'd1;
        update_zn(m_x);
      end
      csic_pkg::OP_JMP_ABS: begin
        m_pc = fetch_word(m_pc + 16'd1);
      end
      csic_pkg::OP_BRK: begin
        ret = m_pc + 16'd2;
        push_stack(ret[15:8]);
        push_stack(ret[7:0]);
        push_stack(m_flags | csic_pkg::FLAG_B);
        m_flags = (m_flags | csic_pkg::FLAG_I) & ~csic_pkg::FLAG_B;
        m_pc = fetch_word(csic_pkg::VEC_IRQ);
      end
      default: begin
        m_halt = 1'b1;
      end
    endcase
    return op;
  endfunction

  // apply one accepted word and queue the snapshot it should produce
  function automatic void step_core(logic [1:0] c, logic [15:0] a, logic [7:0] d);
    core_snapshot_t s;
    s.rd = 8'h00;
    s.op = 8'h00;
    case (c)
      csic_pkg::CMD_WRITE: core_mem[a] = d;
      csic_pkg::CMD_READ:  s.rd = core_mem[a];
      csic_pkg::CMD_EXEC:  if (!m_halt) s.op = exec_instr();
      default: ;
    endcase
    s.pc = m_pc;
    s.acc = m_acc;
    s.x = m_x;
    s.sp = m_sp;
    s.flags = m_flags;
    s.halt = m_halt;
    snapshot_q.push_back(s);
  endfunction

  // ---------------------------------------------------------------- driver

  // sends words in bursts with gaps; an accepted word goes into the model
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= csic_pkg::CMD_WRITE;
      mem_address_i <= '0;
      write_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) step_core(cmd_i, mem_address_i, write_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (cmd_words_q.size() != 0) begin
          next_word = cmd_words_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i <= next_word.cmd;
          mem_address_i <= next_word.addr;
          write_data_i <= next_word.data;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            send_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // compares each output word with the oldest snapshot; stalls in phases
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (snapshot_q.size() == 0) begin
          $error("output word with no snapshot waiting");
          errors++;
        end else begin
          exp_snap = snapshot_q.pop_front();
          check_field("read_data", 16'(exp_snap.rd), 16'(read_data_o));
          check_field("program_counter", exp_snap.pc, program_counter_o);
          check_field("accumulator", 16'(exp_snap.acc), 16'(accumulator_o));
          check_field("index_x", 16'(exp_snap.x), 16'(index_x_o));
          check_field("stack_pointer", 16'(exp_snap.sp), 16'(stack_pointer_o));
          check_field("status_flags", 16'(exp_snap.flags), 16'(status_flags_o));
          check_field("halted", 16'(exp_snap.halt), 16'(halted_o));
          check_field("fetched_opcode", 16'(exp_snap.op), 16'(fetched_opcode_o));
        end
      end
      // stall pattern: none, coin flip or heavy, each for a stretch
      if (stall_len == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_len <= $urandom_range(20, 300);
      end else begin
        stall_len <= stall_len - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_word(logic [1:0] c, logic [15:0] a, logic [7:0] d);
    cmd_words_q.push_back('{cmd: c, addr: a, data: d});
    words_queued++;
  endtask

  // wait until every queued word is accepted, so the model state is current
  task automatic wait_accepted();
    @(negedge clk_i);
    while (cmd_words_q.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    wait_accepted();
    while (snapshot_q.size() != 0) @(negedge clk_i);
  endtask

  // random byte with extra weight on the corner values
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  // address outside the program region and the irq vector
  function automatic logic [15:0] pick_free_addr(logic [15:0] base);
    logic [15:0] a;
    logic [15:0] span;
    do begin
      a = 16'($urandom());
      span = a - base;
    end while (span < 16'd64 || a >= csic_pkg::VEC_IRQ);
    return a;
  endfunction

  // random reads, writes and unused commands; no execution
  task automatic queue_noise();
    int pick;
    repeat ($urandom_range(4, 12)) begin
      pick = $urandom_range(0, 2);
      queue_word((pick == 0) ? csic_pkg::CMD_WRITE :
                 (pick == 1) ? csic_pkg::CMD_READ : CMD_UNUSED,
                 16'($urandom()), pick_byte());
    end
  endtask

  // jump from the current pc into a fresh random program and run it
  task automatic queue_program();
    logic [15:0] entry;
    logic [15:0] base;
    logic [15:0] pos;
    logic [15:0] a;
    logic [15:0] vec;
    logic [7:0]  code [$];
    int          n_instr;
    int          n_exec;
    int          kind;
    bit          brk_done;
    entry = m_pc;
    base = 16'($urandom_range(16'h0200, 16'hEF00));
    queue_word(csic_pkg::CMD_WRITE, entry, csic_pkg::OP_JMP_ABS);
    queue_word(csic_pkg::CMD_WRITE, entry + 16'd1, base[7:0]);
    queue_word(csic_pkg::CMD_WRITE, entry + 16'd2, base[15:8]);
    queue_word(csic_pkg::CMD_EXEC, 16'($urandom()), pick_byte());
    n_instr = 0;
    brk_done = 1'b0;
    vec = '0;
    repeat ($urandom_range(3, 10)) begin
      kind = $urandom_range(0, 6);
      if (kind == 6 && brk_done) kind = 4;
      case (kind)
        0: begin
          code.push_back(csic_pkg::OP_LDX_IMM);
          code.push_back(pick_byte());
        end
        1: begin
          // sometimes read back from the stack page
          a = ($urandom_range(0, 3) == 0) ? {8'h01, pick_byte()} : 16'($urandom());
          code.push_back(csic_pkg::OP_LDA_ABSX);
          code.push_back(a[7:0]);
          code.push_back(a[15:8]);
        end
        2: begin
          a = pick_free_addr(base);
          code.push_back(csic_pkg::OP_STA_ABS);
          code.push_back(a[7:0]);
          code.push_back(a[15:8]);
        end
        3: begin
          // taken or not, the branch lands on the next instruction or skips the one filler after it
          code.push_back(csic_pkg::OP_BEQ);
          case ($urandom_range(0, 2))
            0: code.push_back(8'h00);
            1: begin
              code.push_back(8'h01);
              code.push_back(csic_pkg::OP_INX);
              n_instr++;
            end
            default: begin
              code.push_back(8'h02);
              code.push_back(csic_pkg::OP_LDX_IMM);
              code.push_back(pick_byte());
              n_instr++;
            end
          endcase
        end
        4: code.push_back(csic_pkg::OP_INX);
        5: begin
          pos = base + 16'(code.size()) + 16'd3;
          code.push_back(csic_pkg::OP_JMP_ABS);
          code.push_back(pos[7:0]);
          code.push_back(pos[15:8]);
        end
        default: begin
          code.push_back(csic_pkg::OP_BRK);
          vec = base + 16'(code.size());
          brk_done = 1'b1;
        end
      endcase
      n_instr++;
    end
    // closing jump to itself absorbs any surplus execute
    pos = base + 16'(code.size());
    code.push_back(csic_pkg::OP_JMP_ABS);
    code.push_back(pos[7:0]);
    code.push_back(pos[15:8]);
    n_instr++;
    for (int i = 0; i < code.size(); i++) begin
      queue_word(csic_pkg::CMD_WRITE, base + 16'(i), code[i]);
    end
    if (brk_done) begin
      queue_word(csic_pkg::CMD_WRITE, csic_pkg::VEC_IRQ, vec[7:0]);
      queue_word(csic_pkg::CMD_WRITE, csic_pkg::VEC_IRQ + 16'd1, vec[15:8]);
    end
    // sometimes stop midway; the next program starts from there
    n_exec = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_instr) : n_instr;
    repeat (n_exec) begin
      case ($urandom_range(0, 9))
        0: queue_word(csic_pkg::CMD_READ, 16'($urandom()), pick_byte());
        1: queue_word(csic_pkg::CMD_READ, {8'h01, pick_byte()}, pick_byte());
        2: queue_word(csic_pkg::CMD_WRITE, pick_free_addr(base), pick_byte());
        3: queue_word(CMD_UNUSED, 16'($urandom()), pick_byte());
        default: ;
      endcase
      queue_word(csic_pkg::CMD_EXEC, 16'($urandom()), pick_byte());
    end
  endtask

  initial begin
    int          seg;
    logic [7:0]  op;
    logic [15:0] a;
    for (int i = 0; i < 65536; i++) core_mem[i] = 8'h00;
    m_pc = csic_pkg::VEC_RESET;
    m_acc = 8'h00;
    m_x = 8'h00;
    m_sp = csic_pkg::SP_RESET;
    m_flags = 8'h00;
    m_halt = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: brk from cleared memory, then every opcode with wrapping operands
    queue_word(csic_pkg::CMD_READ, 16'h0000, 8'hFF);
    queue_word(csic_pkg::CMD_EXEC, 16'hFFFF, 8'h00);
    queue_word(csic_pkg::CMD_WRITE, 16'h0000, csic_pkg::OP_LDX_IMM);
    queue_word(csic_pkg::CMD_WRITE, 16'h0001, 8'h00);
    queue_word(csic_pkg::CMD_WRITE, 16'h0002, csic_pkg::OP_BEQ);
    queue_word(csic_pkg::CMD_WRITE, 16'h0003, 8'h80);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    // branch taken backwards across address zero
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF84, csic_pkg::OP_INX);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF85, csic_pkg::OP_BEQ);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF86, 8'h7F);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    // indexed load wraps to address zero
    queue_word(csic_pkg::CMD_WRITE, 16'hFF87, csic_pkg::OP_LDA_ABSX);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF88, 8'hFF);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF89, 8'hFF);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF8A, csic_pkg::OP_STA_ABS);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF8B, 8'hFF);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF8C, 8'hFF);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF8D, csic_pkg::OP_JMP_ABS);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF8E, 8'hFE);
    queue_word(csic_pkg::CMD_WRITE, 16'hFF8F, 8'hFF);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    queue_word(csic_pkg::CMD_READ, 16'hFFFF, 8'h00);
    queue_word(CMD_UNUSED, 16'hFFFF, 8'hFF);

    // random programs with some noise; every fourth round waits for all output
    seg = 0;
    while (words_queued < 590) begin
      if (seg % 4 == 3) wait_drained();
      else wait_accepted();
      if ($urandom_range(0, 4) == 0) queue_noise();
      else queue_program();
      seg++;
    end

    // unimplemented opcode halts the core; later executes are ignored
    wait_accepted();
    do op = 8'($urandom_range(1, 255));
    while (op inside {csic_pkg::OP_LDX_IMM, csic_pkg::OP_LDA_ABSX, csic_pkg::OP_BEQ,
                      csic_pkg::OP_STA_ABS, csic_pkg::OP_INX, csic_pkg::OP_JMP_ABS});
    a = 16'($urandom());
    queue_word(csic_pkg::CMD_WRITE, m_pc, op);
    queue_word(csic_pkg::CMD_EXEC, 16'h0000, 8'h00);
    queue_word(csic_pkg::CMD_EXEC, 16'hFFFF, 8'hFF);
    queue_word(csic_pkg::CMD_WRITE, a, pick_byte());
    queue_word(csic_pkg::CMD_READ, a, 8'h00);
    queue_word(CMD_UNUSED, a, 8'hFF);
    queue_word(csic_pkg::CMD_EXEC, a, 8'h00);
    queue_word(csic_pkg::CMD_READ, m_pc, 8'h00);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_cpu_subset_instruction_core_unit: PASS");
    end else begin
      $display("tb_cpu_subset_instruction_core_unit: FAIL");
    end
    $finish;
  end

  // watchdog: memory clear after reset plus a slow run, several times over
  initial begin
    #10_000_000;
    $display("tb_cpu_subset_instruction_core_unit: FAIL");
    $finish;
  end

endmodule
